// ----- rtl/core/kbsc_pkg.sv -----
package kbsc_pkg;

    // Widths fixed by the item and register layout
    localparam int unsigned DATA_W      = 8;
    localparam int unsigned LEN_W       = 4;
    localparam int unsigned KEY_LO_W    = 64;
    localparam int unsigned KEY_HI_W    = 56;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned MAX_KEY_BYTES = 15;

    // ASCII letter bounds
    localparam logic [DATA_W-1:0] UPPER_A = 8'h41;
    localparam logic [DATA_W-1:0] UPPER_Z = 8'h5A;
    localparam logic [DATA_W-1:0] LOWER_A = 8'h61;
    localparam logic [DATA_W-1:0] LOWER_Z = 8'h7A;
    localparam logic [5:0]        ALPHA   = 6'd26;

    typedef enum logic [1:0] {
        MODE_ENC  = 2'd0,
        MODE_DEC  = 2'd1,
        MODE_XOR  = 2'd2,
        MODE_PASS = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE    = 2'd0,
        CFG_KEY_LEN = 2'd1,
        CFG_KEY_LO  = 2'd2,
        CFG_KEY_HI  = 2'd3
    } t_cfg_idx;

    // Status from the key unit to the datapath
    typedef struct packed {
        t_mode             mode;
        logic [LEN_W-1:0]  key_pos;
    } t_key_stat;

endpackage

// ----- rtl/core/kbsc_key.sv -----
// Config registers, key position counter and key byte select.
module kbsc_key #(
    parameter int unsigned KEY_BYTES = kbsc_pkg::MAX_KEY_BYTES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [kbsc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [kbsc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_step,
    input  logic                               i_start,
    output logic [kbsc_pkg::DATA_W-1:0]        o_key_byte,
    output kbsc_pkg::t_key_stat                o_stat
);

    localparam logic [kbsc_pkg::LEN_W-1:0] LEN_MAX = kbsc_pkg::LEN_W'(KEY_BYTES);

    kbsc_pkg::t_mode                   r_mode;
    logic [kbsc_pkg::LEN_W-1:0]        r_key_len;
    logic [kbsc_pkg::KEY_LO_W-1:0]     r_key_lo;
    logic [kbsc_pkg::KEY_HI_W-1:0]     r_key_hi;
    logic [kbsc_pkg::LEN_W-1:0]        r_pos;
    logic [kbsc_pkg::LEN_W-1:0]        n_pos;

    logic [kbsc_pkg::LEN_W-1:0]        eff_len;
    logic [kbsc_pkg::LEN_W-1:0]        cur_pos;
    logic [kbsc_pkg::LEN_W-1:0]        inc_pos;
    logic [kbsc_pkg::KEY_HI_W+kbsc_pkg::KEY_LO_W-1:0] key_all;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= kbsc_pkg::MODE_ENC;
            r_key_len <= kbsc_pkg::LEN_W'(1);
            r_key_lo  <= '0;
            r_key_hi  <= '0;
        end else if (i_cfg_valid) begin
            case (kbsc_pkg::t_cfg_idx'(i_cfg_index))
                kbsc_pkg::CFG_MODE:    r_mode    <= kbsc_pkg::t_mode'(i_cfg_data[1:0]);
                kbsc_pkg::CFG_KEY_LEN: r_key_len <= i_cfg_data[kbsc_pkg::LEN_W-1:0];
                kbsc_pkg::CFG_KEY_LO:  r_key_lo  <= i_cfg_data[kbsc_pkg::KEY_LO_W-1:0];
                kbsc_pkg::CFG_KEY_HI:  r_key_hi  <= i_cfg_data[kbsc_pkg::KEY_HI_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero length acts as one; above the key store saturates
    always_comb begin
        if (r_key_len == '0) begin
            eff_len = kbsc_pkg::LEN_W'(1);
        end else if (r_key_len > LEN_MAX) begin
            eff_len = LEN_MAX;
        end else begin
            eff_len = r_key_len;
        end
    end

    // Start of message, or a stale position after a length change, restarts at zero
    always_comb begin
        cur_pos = (i_start || (r_pos >= eff_len)) ? '0 : r_pos;
        inc_pos = cur_pos + kbsc_pkg::LEN_W'(1);
        n_pos   = i_step ? ((inc_pos >= eff_len) ? '0 : inc_pos) : r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    assign key_all    = {r_key_hi, r_key_lo};
    assign o_key_byte = key_all[{cur_pos, 3'b000} +: kbsc_pkg::DATA_W];

    assign o_stat.mode    = r_mode;
    assign o_stat.key_pos = r_pos;

endmodule

// ----- rtl/core/kbsc_xform.sv -----
// Byte transform: letter shift forward or back by key mod 26, xor, or pass.
module kbsc_xform (
    input  kbsc_pkg::t_mode                  i_mode,
    input  logic [kbsc_pkg::DATA_W-1:0]      i_data,
    input  logic [kbsc_pkg::DATA_W-1:0]      i_key,
    output logic [kbsc_pkg::DATA_W-1:0]      o_data
);

    logic [14:0]                       recip;
    logic [3:0]                        quot;
    logic [kbsc_pkg::DATA_W-1:0]       rem;
    logic [4:0]                        shift;
    logic                              is_upper;
    logic                              is_lower;
    logic [kbsc_pkg::DATA_W-1:0]       base;
    logic [kbsc_pkg::DATA_W-1:0]       diff;
    logic [5:0]                        sum;
    logic [5:0]                        wrapped;
    logic [kbsc_pkg::DATA_W-1:0]       shifted;

    always_comb begin
        // key / 26 as (key * 79) >> 11, exact over 0..255
        recip = 15'(i_key) * 15'd79;
        quot  = recip[14:11];
        rem   = i_key - (8'(quot) * 8'd26);
        shift = rem[4:0];

        is_upper = (i_data >= kbsc_pkg::UPPER_A) && (i_data <= kbsc_pkg::UPPER_Z);
        is_lower = (i_data >= kbsc_pkg::LOWER_A) && (i_data <= kbsc_pkg::LOWER_Z);
        base     = is_upper ? kbsc_pkg::UPPER_A : kbsc_pkg::LOWER_A;
        diff     = i_data - base;

        if (i_mode == kbsc_pkg::MODE_DEC) begin
            sum = 6'(diff[4:0]) + kbsc_pkg::ALPHA - 6'(shift);
        end else begin
            sum = 6'(diff[4:0]) + 6'(shift);
        end
        wrapped = (sum >= kbsc_pkg::ALPHA) ? (sum - kbsc_pkg::ALPHA) : sum;
        shifted = (is_upper || is_lower) ? (base + 8'(wrapped)) : i_data;

        case (i_mode)
            kbsc_pkg::MODE_ENC,
            kbsc_pkg::MODE_DEC: o_data = shifted;
            kbsc_pkg::MODE_XOR: o_data = i_data ^ i_key;
            default:            o_data = i_data;
        endcase
    end

endmodule

// ----- rtl/core/keyed_byte_stream_cipher.sv -----
// Keyed byte stream cipher (Vigenere letter shift with an xor mode).
//
// Input channel: i_valid / o_stall carry one item per accepted edge,
// a data byte plus a start-of-message flag that rewinds the key position
// to byte 0 before that byte is used. Output channel: o_valid / i_stall
// carry the transformed byte. Config channel: i_cfg_valid / o_cfg_ready
// with a register index (0 mode, 1 key length, 2 key bytes 0-7,
// 3 key bytes 8-14); ready is always high. Write config only while idle.
//
// Pipeline: input register, then result register; an accepted item moves
// into the result register when it is free, and o_valid then rises.
// Throughput: one item per cycle, back to back, while i_stall is low.
//
// Reset (synchronous, i_rst_n low): mode encrypt, key length 1, key zero,
// key position 0, both pipeline stages empty.
// Stall: while i_stall is high the result register holds its item; the
// input register still fills if empty, after which o_stall rises.
module keyed_byte_stream_cipher #(
    parameter int unsigned KEY_BYTES = kbsc_pkg::MAX_KEY_BYTES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input items
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [kbsc_pkg::DATA_W-1:0]        i_data_byte,
    input  logic                               i_start_of_message,
    // result items
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [kbsc_pkg::DATA_W-1:0]        o_out_byte,
    // config writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [kbsc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [kbsc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic                              r_s1_valid;
    logic [kbsc_pkg::DATA_W-1:0]       r_s1_data;
    logic [kbsc_pkg::DATA_W-1:0]       r_s1_key;
    logic                              r_out_valid;
    logic [kbsc_pkg::DATA_W-1:0]       r_out_byte;

    logic                              s2_ready;
    logic                              s1_move;
    logic                              in_acc;
    logic [kbsc_pkg::DATA_W-1:0]       sel_key;
    logic [kbsc_pkg::DATA_W-1:0]       n_out_byte;
    kbsc_pkg::t_key_stat               key_stat;

    // Handshake: result register frees when empty or being taken
    assign s2_ready    = !r_out_valid || !i_stall;
    assign s1_move     = r_s1_valid && s2_ready;
    assign o_stall     = r_s1_valid && !s2_ready;
    assign in_acc      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // Key position steps on every accepted item
    kbsc_key #(
        .KEY_BYTES (KEY_BYTES)
    ) u_key (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (in_acc),
        .i_start     (i_start_of_message),
        .o_key_byte  (sel_key),
        .o_stat      (key_stat)
    );

    kbsc_xform u_xform (
        .i_mode (key_stat.mode),
        .i_data (r_s1_data),
        .i_key  (r_s1_key),
        .o_data (n_out_byte)
    );

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_data <= i_data_byte;
            r_s1_key  <= sel_key;
        end
        if (s1_move) begin
            r_out_byte <= n_out_byte;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;

    // Checks
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid))
        else $error("input stall raised with a free stage");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_stat.key_pos < kbsc_pkg::LEN_W'(KEY_BYTES))
        else $error("key position beyond key store");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> (r_s1_valid && $stable(r_s1_data) && $stable(r_s1_key)))
        else $error("input register lost a held item");

    a_xor_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && (key_stat.mode == kbsc_pkg::MODE_XOR))
            |=> (r_out_byte == $past(r_s1_data ^ r_s1_key)))
        else $error("xor result mismatch");

endmodule
